FILE: rtl/core/sis_pkg.sv
// Shared types and constants for the sorted insert stack.
// Used by sis_ctrl, sis_datapath and sorted_insert_stack_core; no dependencies.
`default_nettype none

package sis_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic [OUT_CNT_W-1:0]    count;
    logic                    is_empty;
    logic                    error;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the accepted input beat
    logic exec;    // apply the held operation and load the result register
    logic refuse;  // the held operation is refused: state stays, error flag set
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic is_pop;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_insert_stack_core.sv
// Top level of the sorted insert stack: joins the controller and the datapath.
// Depends on sis_pkg, sis_ctrl and sis_datapath.
//
//   Channel  Direction  Handshake             Beat contents
//   in_      input      in_valid / in_stall   sis_pkg::in_item_t  (kind, value)
//   out_     output     out_valid / out_stall sis_pkg::out_item_t (top, count, flags)
//
// Each operation is accepted in the idle state, then in the execute state runs the
// compare-and-shift over all sixteen cells at once and loads the result register.
// A new beat is accepted while the previous result still waits in that register.
// A stalled result holds the next operation in its execute cycle until it drains.
// Reset clears the entry count and the handshake state; no clearing pass.
`default_nettype none

module sorted_insert_stack_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sis_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sis_pkg::out_item_t out_item
);
  import sis_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sis_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sis_datapath.sv
// Datapath of the sorted insert stack: input register, sorted cell chain and
// result register. Depends on sis_pkg.
`default_nettype none

module sis_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sis_pkg::in_item_t  in_item,
  input  sis_pkg::dp_cmd_t   cmd,
  output sis_pkg::dp_sts_t   sts,
  output sis_pkg::out_item_t out_item
);
  import sis_pkg::*;

  in_item_t                item_r;
  logic signed [VAL_W-1:0] cell_r   [DEPTH];
  logic signed [VAL_W-1:0] cell_nxt [DEPTH];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [DEPTH-1:0]        smaller;
  out_item_t               res_r, res_nxt;
  logic                    do_push, do_pop;

  // Cell 0 is the top. Entries are ascending from the top down, so the cells
  // holding values strictly below the new value form a prefix of the chain.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      smaller[i] = (CNT_W'(i) < count_r) && (cell_r[i] < item_r.value);
    end
  end

  assign do_push = cmd.exec && !cmd.refuse && (item_r.kind == KIND_PUSH);
  assign do_pop  = cmd.exec && !cmd.refuse && (item_r.kind == KIND_POP);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_push) begin
        if (smaller[i]) begin
          cell_nxt[i] = cell_r[i];
        end else if (i == 0) begin
          cell_nxt[i] = item_r.value;
        end else if (smaller[(i == 0) ? 0 : i-1]) begin
          cell_nxt[i] = item_r.value;
        end else begin
          cell_nxt[i] = cell_r[(i == 0) ? 0 : i-1];
        end
      end else if (do_pop && (i < DEPTH-1)) begin
        cell_nxt[i] = cell_r[(i < DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    res_nxt.top_value = '0;
    if (do_push) begin
      res_nxt.top_value = smaller[0] ? cell_r[0] : item_r.value;
    end else if (do_pop) begin
      if (count_r > CNT_W'(1)) begin
        res_nxt.top_value = cell_r[1];
      end
    end else if (count_r != '0) begin
      res_nxt.top_value = cell_r[0];
    end
    res_nxt.count    = OUT_CNT_W'(count_nxt);
    res_nxt.is_empty = (count_nxt == '0);
    res_nxt.error    = cmd.refuse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
    for (int i = 0; i < DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  assign sts.full   = (count_r == CNT_W'(DEPTH));
  assign sts.empty  = (count_r == '0);
  assign sts.is_pop = (item_r.kind == KIND_POP);
  assign out_item   = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_refuse_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && cmd.refuse) |=> $stable(count_r))
    else $error("refused operation changed the count");

  a_top_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (cell_r[0] <= cell_r[1]))
    else $error("top entry is not the smallest");

endmodule

`default_nettype wire

FILE: rtl/core/sis_ctrl.sv
// Controller of the sorted insert stack: accept/execute state machine and
// result valid flag. Depends on sis_pkg.
`default_nettype none

module sis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  sis_pkg::dp_sts_t sts,
  output sis_pkg::dp_cmd_t cmd
);
  import sis_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new beat when empty or being drained now.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    cmd.refuse    = sts.is_pop ? sts.empty : sts.full;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed operation produced no result beat");

  a_load_then_exec_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_EXEC))
    else $error("accepted beat not held for execution");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for sorted_insert_stack_core: directed and random push/pop beats.
// Uses sis_pkg for the beat types; keeps its own mirror of the sorted stack for prediction.
`timescale 1ns / 100ps

module testbench;
  import sis_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  sorted_insert_stack_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  in_item_t  op_queue[$];
  out_item_t expected_tops[$];

  // Mirror of the stack: slot 0 is the bottom (largest), slot mirror_count-1 the top.
  logic signed [VAL_W-1:0] stack_mirror[DEPTH];
  int mirror_count;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int cycle_count;
  logic in_taken;

  logic signed [VAL_W-1:0] last_value;

  function automatic out_item_t apply_stack_op(in_item_t beat);
    out_item_t res;
    logic signed [VAL_W-1:0] v;
    int pos;
    v = beat.value;
    res.error = 1'b0;
    if (beat.kind == KIND_PUSH) begin
      if (mirror_count >= DEPTH) begin
        res.error = 1'b1;
      end else begin
        pos = mirror_count;
        while (pos > 0 && v > stack_mirror[pos-1]) begin
          stack_mirror[pos] = stack_mirror[pos-1];
          pos--;
        end
        stack_mirror[pos] = v;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        res.error = 1'b1;
      end else begin
        mirror_count--;
      end
    end
    res.top_value = (mirror_count > 0) ? stack_mirror[mirror_count-1] : '0;
    res.count = mirror_count[OUT_CNT_W-1:0];
    res.is_empty = (mirror_count == 0);
    return res;
  endfunction

  task automatic queue_op(kind_t kind, logic signed [VAL_W-1:0] value);
    in_item_t beat;
    beat.kind = kind;
    beat.value = value;
    op_queue = {op_queue, beat};
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7: v = $signed($urandom_range(0, 6)) - 3;
      8: v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: v = last_value;
    endcase
    return v;
  endfunction

  // Segments are picked at random among filling, draining and an even mix so that the
  // stack walks the whole range from empty to full and back.
  task automatic queue_random_ops(int n);
    int left;
    int seg;
    int push_pct;
    logic signed [VAL_W-1:0] v;
    left = n;
    while (left > 0) begin
      seg = $urandom_range(4, 24);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < seg && left > 0; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          v = pick_value();
          last_value = v;
          queue_op(KIND_PUSH, v);
        end else begin
          queue_op(KIND_POP, $urandom);
        end
        left--;
      end
    end
  endtask

  task automatic wait_until_drained();
    while (op_queue.size() != 0 || in_valid || expected_tops.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: a new beat is presented at the falling edge once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= op_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: predicts on each accepted input beat and checks each accepted result.
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_tops = {expected_tops, apply_stack_op(in_item)};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tops.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result beat: top %0d count %0d empty %0b error %0b",
                   out_item.top_value, out_item.count, out_item.is_empty,
                   out_item.error);
        end
      end else begin
        want = expected_tops.pop_front();
        if (out_item.top_value !== want.top_value || out_item.count !== want.count ||
            out_item.is_empty !== want.is_empty || out_item.error !== want.error) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result mismatch: top %0d/%0d count %0d/%0d empty %0b/%0b error %0b/%0b",
                     want.top_value, out_item.top_value, want.count, out_item.count,
                     want.is_empty, out_item.is_empty, want.error, out_item.error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    mirror_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    last_value = '0;
    send_idle_pct = 25;
    recv_idle_pct = 56;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pop on an empty stack, the value extremes, equal values, then
    // drain back to empty and refuse one more pop.
    queue_op(KIND_POP, 32'shffff_ffff);
    queue_op(KIND_PUSH, 32'sh7fff_ffff);
    queue_op(KIND_PUSH, 32'sh8000_0000);
    queue_op(KIND_PUSH, 32'sh0);
    queue_op(KIND_PUSH, 32'sh0);
    queue_op(KIND_PUSH, -32'sd1);
    queue_op(KIND_PUSH, 32'sd1);
    repeat (6) queue_op(KIND_POP, $urandom);
    queue_op(KIND_POP, 32'sh0);
    // Fill past the depth so a push on a full stack is refused, then empty it.
    for (int i = 0; i < DEPTH + 1; i++) begin
      queue_op(KIND_PUSH, $signed($urandom_range(0, 8)) - 4);
    end
    for (int i = 0; i < DEPTH; i++) begin
      queue_op(KIND_POP, $urandom);
    end
    queue_random_ops(150);
    wait_until_drained();

    send_idle_pct = 56;
    recv_idle_pct = 25;
    queue_random_ops(170);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_ops(170);
    wait_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_tops.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
